// ----- src/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Shared types, codes and constants of the phoneme feature accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfa_pkg;

    localparam int NCLASS        = 6;
    localparam int QUEUE_DEPTH   = 4;
    localparam int CHECK_STEPS   = 6;

    typedef enum logic [1:0] {
        OP_CLASSIFY = 2'd0,
        OP_CLEAR    = 2'd1,
        OP_READ     = 2'd2,
        OP_UNUSED   = 2'd3
    } t_op;

    localparam logic [2:0] CLS_F    = 3'd0;
    localparam logic [2:0] CLS_E    = 3'd1;
    localparam logic [2:0] CLS_O    = 3'd2;
    localparam logic [2:0] CLS_V    = 3'd3;
    localparam logic [2:0] CLS_S    = 3'd4;
    localparam logic [2:0] CLS_H    = 3'd5;
    localparam logic [2:0] CLS_NONE = 3'd7;

    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_F     = 8'h66;
    localparam logic [7:0] CHR_E     = 8'h65;
    localparam logic [7:0] CHR_O     = 8'h6f;
    localparam logic [7:0] CHR_V     = 8'h76;
    localparam logic [7:0] CHR_S     = 8'h73;
    localparam logic [7:0] CHR_H     = 8'h68;

    localparam logic [1:0] CFG_WINDOW_MASK  = 2'd0;
    localparam logic [1:0] CFG_PLOSIVE_TIME = 2'd1;
    localparam logic [1:0] CFG_VOICE_LIMIT  = 2'd2;

    localparam logic [7:0]  RST_WINDOW_MASK  = 8'd15;
    localparam logic [15:0] RST_PLOSIVE_TIME = 16'd300;
    localparam logic [7:0]  RST_VOICE_LIMIT  = 8'd15;

    localparam logic [4:0] FEAT_TOTAL_LAST = 5'd5;
    localparam logic [4:0] FEAT_MOD_FIRST  = 5'd6;
    localparam logic [4:0] FEAT_MOD_LAST   = 5'd11;
    localparam logic [4:0] FEAT_POS_FIRST  = 5'd12;
    localparam logic [4:0] FEAT_POS_LAST   = 5'd17;
    localparam logic [4:0] FEAT_LENGTH     = 5'd18;
    localparam logic [4:0] FEAT_PLOSIVE    = 5'd19;

    localparam logic [2:0] CHECK_ORDER [CHECK_STEPS] =
        '{CLS_F, CLS_E, CLS_O, CLS_S, CLS_H, CLS_V};

    typedef struct packed {
        t_op         op;
        logic [2:0]  cls;
        logic        is_space;
        logic [31:0] time_ms;
        logic [4:0]  feature_index;
    } t_cmd;

endpackage

`default_nettype wire

// ----- src/pfa_front.sv -----
// ----------------------------------------------------------------------------
// pfa_front
// Accepts input items, decodes the phoneme class and pushes commands.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_front (
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [7:0]   i_phoneme,
    input  wire logic [31:0]  i_time_ms,
    input  wire logic [4:0]   i_feature_index,
    input  wire logic         i_q_full,
    output logic              o_q_push,
    output pfa_pkg::t_cmd     o_q_cmd
);

    logic [2:0] cls;

    always_comb begin
        case (i_phoneme)
            pfa_pkg::CHR_F: cls = pfa_pkg::CLS_F;
            pfa_pkg::CHR_E: cls = pfa_pkg::CLS_E;
            pfa_pkg::CHR_O: cls = pfa_pkg::CLS_O;
            pfa_pkg::CHR_V: cls = pfa_pkg::CLS_V;
            pfa_pkg::CHR_S: cls = pfa_pkg::CLS_S;
            pfa_pkg::CHR_H: cls = pfa_pkg::CLS_H;
            default:        cls = pfa_pkg::CLS_NONE;
        endcase
    end

    assign o_in_stall = i_q_full;

    // drop the unused opcode at the door
    assign o_q_push = i_in_valid && !i_q_full &&
                      (pfa_pkg::t_op'(i_opcode) != pfa_pkg::OP_UNUSED);

    always_comb begin
        o_q_cmd.op            = pfa_pkg::t_op'(i_opcode);
        o_q_cmd.cls           = cls;
        o_q_cmd.is_space      = (i_phoneme == pfa_pkg::CHR_SPACE);
        o_q_cmd.time_ms       = i_time_ms;
        o_q_cmd.feature_index = i_feature_index;
    end

endmodule

`default_nettype wire

// ----- src/pfa_queue.sv -----
// ----------------------------------------------------------------------------
// pfa_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_queue #(
    parameter int DEPTH = pfa_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pfa_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output pfa_pkg::t_cmd      o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    pfa_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULLC);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/pfa_back.sv -----
// ----------------------------------------------------------------------------
// pfa_back
// Executes commands: counters, window peaks, feature reads, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pfa_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_valid,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_q_valid,
    input  wire pfa_pkg::t_cmd i_q_cmd,
    output logic               o_q_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output logic [15:0]        o_feature_value
);

    localparam int NC = pfa_pkg::NCLASS;

    logic [7:0]  r_mask;
    logic [15:0] r_ptime;
    logic [7:0]  r_vlim;

    logic [15:0] r_total [NC];
    logic [7:0]  r_wc    [NC];
    logic [7:0]  r_peak  [NC];
    logic [15:0] r_pos   [NC];
    logic [7:0]  r_mod   [NC];
    logic [15:0] r_len;
    logic [15:0] r_plosive;
    logic        r_expect;
    logic [31:0] r_space_time;
    logic [2:0]  r_lead;

    logic [15:0] n_total [NC];
    logic [7:0]  n_wc    [NC];
    logic [7:0]  n_peak  [NC];
    logic [15:0] n_pos   [NC];
    logic [7:0]  n_mod   [NC];
    logic [15:0] n_len;
    logic [15:0] n_plosive;
    logic        n_expect;
    logic [31:0] n_space_time;
    logic [2:0]  n_lead;

    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] rd_value;
    logic        out_free;
    logic        is_read;
    logic        is_classify;
    logic        is_clear;
    logic        close;
    logic [31:0] gap;

    assign is_read     = (i_q_cmd.op == pfa_pkg::OP_READ);
    assign is_classify = (i_q_cmd.op == pfa_pkg::OP_CLASSIFY);
    assign is_clear    = (i_q_cmd.op == pfa_pkg::OP_CLEAR);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_q_pop     = i_q_valid && (!is_read || out_free);

    assign gap   = i_q_cmd.time_ms - r_space_time;
    assign n_len = (is_classify) ? r_len + 16'd1 : r_len;
    assign close = ((n_len[7:0] & r_mask) == 8'd0);

    always_comb begin
        logic [2:0] c;
        logic [7:0] lim;
        logic [2:0] lead;
        for (int k = 0; k < NC; k++) begin
            n_total[k] = r_total[k];
            n_wc[k]    = r_wc[k];
            n_peak[k]  = r_peak[k];
            n_pos[k]   = r_pos[k];
            n_mod[k]   = r_mod[k];
        end
        n_plosive    = r_plosive;
        n_expect     = r_expect;
        n_space_time = r_space_time;
        lead         = r_lead;
        c            = pfa_pkg::CLS_NONE;
        lim          = 8'd0;
        if (is_classify) begin
            if (!r_expect && !i_q_cmd.is_space) begin
                n_expect = 1'b1;
                if (gap < {16'd0, r_ptime} && r_plosive != 16'hffff) begin
                    n_plosive = r_plosive + 16'd1;
                end
            end
            if (i_q_cmd.cls != pfa_pkg::CLS_NONE) begin
                if (r_total[i_q_cmd.cls] != 16'hffff) begin
                    n_total[i_q_cmd.cls] = r_total[i_q_cmd.cls] + 16'd1;
                end
                if (r_wc[i_q_cmd.cls] != 8'hff) begin
                    n_wc[i_q_cmd.cls] = r_wc[i_q_cmd.cls] + 8'd1;
                end
            end else if (i_q_cmd.is_space && r_expect) begin
                n_expect     = 1'b0;
                n_space_time = i_q_cmd.time_ms;
            end
            if (close) begin
                for (int i = 0; i < pfa_pkg::CHECK_STEPS; i++) begin
                    c   = pfa_pkg::CHECK_ORDER[i];
                    lim = (c == pfa_pkg::CLS_V) ? r_vlim : r_mask;
                    if (n_wc[c] > r_peak[c] && r_peak[c] < lim) begin
                        n_peak[c] = n_wc[c];
                        n_pos[c]  = n_len;
                        if (lead != c) begin
                            lead = c;
                            if (r_mod[c] != 8'hff) begin
                                n_mod[c] = r_mod[c] + 8'd1;
                            end
                        end
                    end
                end
                for (int k = 0; k < NC; k++) begin
                    n_wc[k] = 8'd0;
                end
            end
        end else if (is_clear) begin
            for (int k = 0; k < NC; k++) begin
                n_total[k] = 16'd0;
                n_wc[k]    = 8'd0;
                n_mod[k]   = 8'd0;
            end
            n_plosive = 16'd0;
            n_expect  = 1'b1;
        end
        n_lead = lead;
    end

    always_comb begin
        logic [4:0] off;
        off      = 5'd0;
        rd_value = 16'd0;
        case (i_q_cmd.feature_index) inside
            [5'd0 : pfa_pkg::FEAT_TOTAL_LAST]: begin
                rd_value = r_total[i_q_cmd.feature_index[2:0]];
            end
            [pfa_pkg::FEAT_MOD_FIRST : pfa_pkg::FEAT_MOD_LAST]: begin
                off      = i_q_cmd.feature_index - pfa_pkg::FEAT_MOD_FIRST;
                rd_value = {8'd0, r_mod[off[2:0]]};
            end
            [pfa_pkg::FEAT_POS_FIRST : pfa_pkg::FEAT_POS_LAST]: begin
                off      = i_q_cmd.feature_index - pfa_pkg::FEAT_POS_FIRST;
                rd_value = r_pos[off[2:0]];
            end
            pfa_pkg::FEAT_LENGTH:  rd_value = r_len;
            pfa_pkg::FEAT_PLOSIVE: rd_value = r_plosive;
            default:               rd_value = 16'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= pfa_pkg::RST_WINDOW_MASK;
            r_ptime <= pfa_pkg::RST_PLOSIVE_TIME;
            r_vlim  <= pfa_pkg::RST_VOICE_LIMIT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pfa_pkg::CFG_WINDOW_MASK:  r_mask  <= i_cfg_data[7:0];
                pfa_pkg::CFG_PLOSIVE_TIME: r_ptime <= i_cfg_data;
                pfa_pkg::CFG_VOICE_LIMIT:  r_vlim  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NC; k++) begin
                r_total[k] <= 16'd0;
                r_wc[k]    <= 8'd0;
                r_peak[k]  <= 8'd0;
                r_pos[k]   <= 16'd0;
                r_mod[k]   <= 8'd0;
            end
            r_len        <= 16'd0;
            r_plosive    <= 16'd0;
            r_expect     <= 1'b1;
            r_space_time <= 32'd0;
            r_lead       <= pfa_pkg::CLS_NONE;
        end else if (o_q_pop) begin
            for (int k = 0; k < NC; k++) begin
                r_total[k] <= n_total[k];
                r_wc[k]    <= n_wc[k];
                r_peak[k]  <= n_peak[k];
                r_pos[k]   <= n_pos[k];
                r_mod[k]   <= n_mod[k];
            end
            r_len        <= is_clear ? 16'd0 : n_len;
            r_plosive    <= n_plosive;
            r_expect     <= n_expect;
            r_space_time <= n_space_time;
            r_lead       <= n_lead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop && is_read) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && is_read) begin
            r_out_data <= rd_value;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_feature_value = r_out_data;

    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && is_read) |=> r_out_valid)
        else $error("read transfer did not load the output register");

    a_held_result_blocks_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && i_q_valid && is_read) |-> !o_q_pop)
        else $error("read popped while a result is held");

    a_plosive_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_q_pop && is_clear) |=> (r_plosive >= $past(r_plosive)))
        else $error("plosive total decreased without clear");

    a_lead_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lead < 3'd6) || (r_lead == pfa_pkg::CLS_NONE))
        else $error("leading class out of range");

endmodule

`default_nettype wire

// ----- src/phoneme_feature_accumulator.sv -----
// ----------------------------------------------------------------------------
// phoneme_feature_accumulator
// Per-class phoneme counters with window peaks, modality and plosive count.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  in       input      i_in_valid/o_in_stall   opcode, phoneme, time_ms, index
//  out      output     o_out_valid/i_out_stall feature_value
//  cfg      input      i_cfg_valid/o_cfg_ready cfg_index, cfg_data
//
//  One item per cycle unless stalled; each command is executed in the cycle it
//  leaves the queue, and a read result appears in the following cycle.
//  Reset clears all accumulators and loads default register values.
//  A held result stalls only a read at the queue head, and the items behind it.
//  The input stalls when the command queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module phoneme_feature_accumulator #(
    parameter int QUEUE_DEPTH = pfa_pkg::QUEUE_DEPTH
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [7:0]   i_phoneme,
    input  wire logic [31:0]  i_time_ms,
    input  wire logic [4:0]   i_feature_index,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [15:0]       o_feature_value,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);

    logic          q_full;
    logic          q_push;
    logic          q_pop;
    logic          q_valid;
    pfa_pkg::t_cmd q_in_cmd;
    pfa_pkg::t_cmd q_out_cmd;

    assign o_cfg_ready = 1'b1;

    pfa_front u_front (
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_phoneme       (i_phoneme),
        .i_time_ms       (i_time_ms),
        .i_feature_index (i_feature_index),
        .i_q_full        (q_full),
        .o_q_push        (q_push),
        .o_q_cmd         (q_in_cmd)
    );

    pfa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out_cmd)
    );

    pfa_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_cmd         (q_out_cmd),
        .o_q_pop         (q_pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_feature_value (o_feature_value)
    );

endmodule

`default_nettype wire

// ----- verif/pfa_feature_checker.sv -----
// ----------------------------------------------------------------------------
// pfa_feature_checker
// Watches the phoneme, result and register channels of the accumulator.
// Keeps its own copy of the class counters, window peaks, gap tracking and
// registers, computes the value of every accepted feature read, and compares
// each result transfer with the oldest outstanding read.
// ----------------------------------------------------------------------------
module pfa_feature_checker (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    input  wire logic         i_in_stall,
    input  wire logic [1:0]   i_opcode,
    input  wire logic [7:0]   i_phoneme,
    input  wire logic [31:0]  i_time_ms,
    input  wire logic [4:0]   i_feature_index,
    input  wire logic         i_out_valid,
    input  wire logic         i_out_stall,
    input  wire logic [15:0]  i_feature_value,
    input  wire logic         i_cfg_valid,
    input  wire logic         i_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data,
    output int                o_fail_count,
    output int                o_reads_open
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [4:0]  idx;
        logic [15:0] value;
    } t_feature_read;

    t_feature_read feature_reads_q[$];
    int mismatches = 0;
    int open_reads = 0;

    logic [7:0]  win_mask;
    logic [15:0] plosive_ms;
    logic [7:0]  voice_limit;

    logic [15:0] class_tot [pfa_pkg::NCLASS];
    logic [7:0]  win_cnt   [pfa_pkg::NCLASS];
    logic [7:0]  peak_cnt  [pfa_pkg::NCLASS];
    logic [15:0] peak_pos  [pfa_pkg::NCLASS];
    logic [7:0]  modality  [pfa_pkg::NCLASS];
    logic [15:0] item_len;
    logic [15:0] plosive_cnt;
    logic        in_gap;
    logic [31:0] gap_start;
    logic [2:0]  leader;

    assign o_fail_count = mismatches;
    assign o_reads_open = open_reads;

    function automatic logic [2:0] phoneme_class(logic [7:0] ph);
        case (ph)
            pfa_pkg::CHR_F: return pfa_pkg::CLS_F;
            pfa_pkg::CHR_E: return pfa_pkg::CLS_E;
            pfa_pkg::CHR_O: return pfa_pkg::CLS_O;
            pfa_pkg::CHR_V: return pfa_pkg::CLS_V;
            pfa_pkg::CHR_S: return pfa_pkg::CLS_S;
            pfa_pkg::CHR_H: return pfa_pkg::CLS_H;
            default:        return pfa_pkg::CLS_NONE;
        endcase
    endfunction

    task automatic clear_counts();
        for (int i = 0; i < pfa_pkg::NCLASS; i++) begin
            class_tot[i] = '0;
            win_cnt[i]   = '0;
            modality[i]  = '0;
        end
        item_len    = '0;
        plosive_cnt = '0;
        in_gap      = 1'b0;
    endtask

    task automatic reset_counts();
        win_mask    = pfa_pkg::RST_WINDOW_MASK;
        plosive_ms  = pfa_pkg::RST_PLOSIVE_TIME;
        voice_limit = pfa_pkg::RST_VOICE_LIMIT;
        clear_counts();
        for (int i = 0; i < pfa_pkg::NCLASS; i++) begin
            peak_cnt[i] = '0;
            peak_pos[i] = '0;
        end
        gap_start = '0;
        leader    = pfa_pkg::CLS_NONE;
        feature_reads_q.delete();
    endtask

    task automatic count_phoneme(logic [7:0] ph, logic [31:0] now);
        logic [2:0]  cls;
        logic [2:0]  c;
        logic [7:0]  lim;
        logic [31:0] elapsed;
        cls      = phoneme_class(ph);
        item_len = item_len + 16'd1;
        if (in_gap && ph != pfa_pkg::CHR_SPACE) begin
            in_gap  = 1'b0;
            elapsed = now - gap_start;
            if (elapsed < {16'd0, plosive_ms} && plosive_cnt != 16'hFFFF)
                plosive_cnt = plosive_cnt + 16'd1;
        end
        if (cls != pfa_pkg::CLS_NONE) begin
            if (class_tot[cls] != 16'hFFFF) class_tot[cls] = class_tot[cls] + 16'd1;
            if (win_cnt[cls] != 8'hFF) win_cnt[cls] = win_cnt[cls] + 8'd1;
        end else if (ph == pfa_pkg::CHR_SPACE && !in_gap) begin
            in_gap    = 1'b1;
            gap_start = now;
        end
        if ((item_len & {8'd0, win_mask}) == 16'd0) begin
            for (int i = 0; i < pfa_pkg::CHECK_STEPS; i++) begin
                c   = pfa_pkg::CHECK_ORDER[i];
                lim = (c == pfa_pkg::CLS_V) ? voice_limit : win_mask;
                if (win_cnt[c] > peak_cnt[c] && peak_cnt[c] < lim) begin
                    peak_cnt[c] = win_cnt[c];
                    peak_pos[c] = item_len;
                    if (leader != c) begin
                        leader = c;
                        if (modality[c] != 8'hFF) modality[c] = modality[c] + 8'd1;
                    end
                end
            end
            for (int i = 0; i < pfa_pkg::NCLASS; i++) win_cnt[i] = '0;
        end
    endtask

    function automatic logic [15:0] feature_of(logic [4:0] idx);
        if (idx <= pfa_pkg::FEAT_TOTAL_LAST) return class_tot[idx];
        if (idx <= pfa_pkg::FEAT_MOD_LAST)
            return {8'd0, modality[idx - pfa_pkg::FEAT_MOD_FIRST]};
        if (idx <= pfa_pkg::FEAT_POS_LAST)
            return peak_pos[idx - pfa_pkg::FEAT_POS_FIRST];
        if (idx == pfa_pkg::FEAT_LENGTH) return item_len;
        if (idx == pfa_pkg::FEAT_PLOSIVE) return plosive_cnt;
        return '0;
    endfunction

    always @(posedge i_clk) begin : watch
        t_feature_read want;
        t_feature_read entry;
        if (!i_rst_n) begin
            reset_counts();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (feature_reads_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: result %h with no read outstanding",
                             $time, i_feature_value);
                end else begin
                    want = feature_reads_q.pop_front();
                    if (i_feature_value !== want.value) begin
                        mismatches++;
                        $display("%0t: feature %0d expected %h got %h",
                                 $time, want.idx, want.value, i_feature_value);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    pfa_pkg::CFG_WINDOW_MASK:  win_mask    = i_cfg_data[7:0];
                    pfa_pkg::CFG_PLOSIVE_TIME: plosive_ms  = i_cfg_data;
                    pfa_pkg::CFG_VOICE_LIMIT:  voice_limit = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (pfa_pkg::t_op'(i_opcode))
                    pfa_pkg::OP_CLASSIFY: count_phoneme(i_phoneme, i_time_ms);
                    pfa_pkg::OP_CLEAR:    clear_counts();
                    pfa_pkg::OP_READ: begin
                        entry.idx   = i_feature_index;
                        entry.value = feature_of(i_feature_index);
                        feature_reads_q.push_back(entry);
                    end
                    default: ;
                endcase
            end
        end
        open_reads = feature_reads_q.size();
    end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Phoneme feature accumulator testbench. Drives a directed opening sequence,
// then phases of random phonemes, clears and feature reads under several
// register settings and idle patterns, including a long result hold-off.
// Prediction and comparison live in pfa_feature_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = pfa_pkg::QUEUE_DEPTH + 4;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 320;

    localparam logic [7:0]  PH_MASK    [PHASES] = '{8'd15, 8'd1, 8'd255, 8'd3, 8'd7, 8'd128};
    localparam logic [15:0] PH_PLOSIVE [PHASES] =
        '{16'd300, 16'd0, 16'hFFFF, 16'd120, 16'd2500, 16'd400};
    localparam logic [7:0]  PH_VOICE   [PHASES] = '{8'd15, 8'd0, 8'd255, 8'd2, 8'd6, 8'd200};

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_in_valid      = 1'b0;
    logic [1:0]  i_opcode        = pfa_pkg::OP_CLASSIFY;
    logic [7:0]  i_phoneme       = '0;
    logic [31:0] i_time_ms       = '0;
    logic [4:0]  i_feature_index = '0;
    logic        i_out_stall     = 1'b0;
    logic        i_cfg_valid     = 1'b0;
    logic [1:0]  i_cfg_index     = pfa_pkg::CFG_WINDOW_MASK;
    logic [15:0] i_cfg_data      = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_feature_value;
    logic        o_cfg_ready;

    int          fail_count;
    int          reads_open;
    int          send_idle_pct = 6;
    int          rcv_stall_pct = 80;
    int          hold_request  = 0;
    int          hold_left     = 0;
    logic [31:0] stamp         = '0;
    logic [7:0]  cur_mask      = pfa_pkg::RST_WINDOW_MASK;

    phoneme_feature_accumulator i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_phoneme       (i_phoneme),
        .i_time_ms       (i_time_ms),
        .i_feature_index (i_feature_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_feature_value (o_feature_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    pfa_feature_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_opcode        (i_opcode),
        .i_phoneme       (i_phoneme),
        .i_time_ms       (i_time_ms),
        .i_feature_index (i_feature_index),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_feature_value (o_feature_value),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_fail_count    (fail_count),
        .o_reads_open    (reads_open)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
        end
    end

    initial begin
        #5_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    task automatic send_item(pfa_pkg::t_op op, logic [7:0] ph, logic [31:0] t,
                             logic [4:0] idx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_opcode        <= op;
        i_phoneme       <= ph;
        i_time_ms       <= t;
        i_feature_index <= idx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic wait_results(bit drain);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (reads_open != 0) @(posedge i_clk);
        if (drain) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_phoneme();
        case ($urandom_range(0, 9))
            0:       return pfa_pkg::CHR_F;
            1:       return pfa_pkg::CHR_E;
            2:       return pfa_pkg::CHR_O;
            3:       return pfa_pkg::CHR_V;
            4:       return pfa_pkg::CHR_S;
            5:       return pfa_pkg::CHR_H;
            6, 7:    return pfa_pkg::CHR_SPACE;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] next_stamp();
        if ($urandom_range(0, 19) == 0) stamp = $urandom;
        else stamp = stamp + 32'($urandom_range(0, 250));
        return stamp;
    endfunction

    function automatic logic [4:0] pick_index();
        if ($urandom_range(0, 9) == 0) return 5'($urandom);
        return 5'($urandom_range(0, 19));
    endfunction

    task automatic run_directed();
        send_item(pfa_pkg::OP_READ,     8'h00,              32'd0,         5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_F,     32'd0,         5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_E,     32'd10,        5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_O,     32'd20,        5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_V,     32'd30,        5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_S,     32'd40,        5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_H,     32'd50,        5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_SPACE, 32'd1000,      5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_SPACE, 32'd1010,      5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, "x",                32'd1100,      5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_SPACE, 32'd5000,      5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_F,     32'd5400,      5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, 8'hFF,              32'hFFFF_FFFF, 5'd31);
        send_item(pfa_pkg::OP_CLASSIFY, 8'h00,              32'd0,         5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_SPACE, 32'hFFFF_FF00, 5'd0);
        send_item(pfa_pkg::OP_CLASSIFY, pfa_pkg::CHR_E,     32'h0000_0010, 5'd0);
        send_item(pfa_pkg::OP_UNUSED,   8'hFF,              32'hFFFF_FFFF, 5'd31);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, pfa_pkg::FEAT_PLOSIVE);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, pfa_pkg::FEAT_LENGTH);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, pfa_pkg::FEAT_POS_FIRST);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, pfa_pkg::FEAT_MOD_FIRST);
        send_item(pfa_pkg::OP_READ, 8'hFF, 32'hFFFF_FFFF, 5'd31);
        send_item(pfa_pkg::OP_CLEAR, 8'h00, 32'd0, 5'd0);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, 5'd0);
        send_item(pfa_pkg::OP_READ, 8'h00, 32'd0, pfa_pkg::FEAT_LENGTH);
    endtask

    task automatic send_random(ref int sent);
        int         pick;
        int         run_len;
        logic [7:0] ph;
        pick = $urandom_range(0, 99);
        if (pick == 0) begin
            run_len = (cur_mask >= 8'd128) ? $urandom_range(100, 300) : $urandom_range(2, 20);
            ph = pick_phoneme();
            repeat (run_len) send_item(pfa_pkg::OP_CLASSIFY, ph, next_stamp(), 5'($urandom));
            sent += run_len;
        end else begin
            if (pick < 62)
                send_item(pfa_pkg::OP_CLASSIFY, pick_phoneme(), next_stamp(), 5'($urandom));
            else if (pick < 92)
                send_item(pfa_pkg::OP_READ, 8'($urandom), next_stamp(), pick_index());
            else if (pick < 96)
                send_item(pfa_pkg::OP_CLEAR, 8'($urandom), $urandom, 5'($urandom));
            else
                send_item(pfa_pkg::OP_UNUSED, 8'($urandom), $urandom, 5'($urandom));
            sent++;
        end
    endtask

    initial begin : stimulus
        int sent;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            wait_results(1'b1);
            write_reg(pfa_pkg::CFG_WINDOW_MASK, {8'($urandom), PH_MASK[p]});
            write_reg(pfa_pkg::CFG_PLOSIVE_TIME, PH_PLOSIVE[p]);
            write_reg(pfa_pkg::CFG_VOICE_LIMIT, {8'($urandom), PH_VOICE[p]});
            i_cfg_valid <= 1'b0;
            cur_mask      = PH_MASK[p];
            send_idle_pct = (p < 2) ? 6 : (p < 4) ? 80 : 0;
            rcv_stall_pct = (p < 2) ? 80 : (p < 4) ? 6 : 0;
            sent = 0;
            if (p == 4) begin
                hold_request = 150;
                repeat (30)
                    send_item(pfa_pkg::OP_READ, 8'($urandom), next_stamp(), pick_index());
                sent = 30;
            end
            while (sent < PHASE_ITEMS) begin
                if (p == 2 && sent == PHASE_ITEMS / 2) wait_results(1'b0);
                send_random(sent);
            end
        end
        wait_results(1'b1);
        if (fail_count == 0 && reads_open == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/pfa_pkg.sv
src/pfa_front.sv
src/pfa_queue.sv
src/pfa_back.sv
src/phoneme_feature_accumulator.sv
verif/pfa_feature_checker.sv
verif/tb_top.sv
